// ===== hw/rtl/hpq_pkg.sv =====
// Shared constants, codes and the entry compare for the heap priority queue.
`default_nettype none

package hpq_pkg;

    // Defaults for the top-level parameters
    localparam int DEFAULT_CAPACITY    = 1024;
    localparam int DEFAULT_ENTRY_WIDTH = 32;
    localparam int MAX_ENTRY_WIDTH     = 64;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [1:0] status_t;

    // Result status codes
    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef logic [MAX_ENTRY_WIDTH-1:0] wide_entry_t;

    // True when entry a is served strictly ahead of entry b
    function automatic logic served_before(wide_entry_t a, wide_entry_t b, logic max_first);
        logic res;
        if (max_first)
            res = (a > b);
        else
            res = (a < b);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hpq_mem.sv =====
// Heap storage: one write port, two read ports with registered read data.
`default_nettype none

module hpq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr_a,
    input  wire logic [AW-1:0]    rd_addr_b,
    output logic      [WIDTH-1:0] rd_data_a,
    output logic      [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: request sequencer and sift engine.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+-------------------------------
//  request   | opcode, entry_value                       | taken when start & !busy
//  result    | top_entry, top_valid, status, entry_count | done high for one cycle
//  config    | cfg_wr_en, cfg_wr_data (order select)     | written when cfg_wr_en high
//
// Insert: each heap level climbed takes a parent read (S_UP_RD) and a compare and
// write-back (S_UP_CMP); the climb ends at the root or when a compare stops it.
// Remove: root and last entry are fetched together (S_RM_RD, S_RM_CAP); unless that empties
// the heap, each level walked down then takes a memory read of both children and a compare
// and write-back, until a leaf or a compare stops it. A new request is taken in the done cycle.
// Remove on empty and insert on full answer in the cycle after the request.
// Reset clears the count and order select; heap storage is not cleared.
// The receiver cannot stall; busy holds off requests while a sift runs.
`default_nettype none

module binary_heap_priority_queue #(
    parameter int CAPACITY    = hpq_pkg::DEFAULT_CAPACITY,
    parameter int ENTRY_WIDTH = hpq_pkg::DEFAULT_ENTRY_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               opcode,
    input  wire logic [ENTRY_WIDTH-1:0]             entry_value,
    output logic                                    done,
    output logic      [ENTRY_WIDTH-1:0]             top_entry,
    output logic                                    top_valid,
    output hpq_pkg::status_t                        status,
    output logic      [$clog2(CAPACITY+1)-1:0]      entry_count,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_wr_data
);

    import hpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int EW = AW + 2;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_RM_RD  = 3'd3;
    localparam logic [2:0] S_RM_CAP = 3'd4;
    localparam logic [2:0] S_DN_RD  = 3'd5;
    localparam logic [2:0] S_DN_CMP = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   order_reg;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [ENTRY_WIDTH-1:0] val_reg, val_next;
    logic [ENTRY_WIDTH-1:0] top_reg, top_next;
    logic                   valid_reg, valid_next;
    status_t                status_reg, status_next;
    logic                   done_reg, done_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic [AW-1:0]          rd_addr_a, rd_addr_b;
    logic [ENTRY_WIDTH-1:0] rd_data_a, rd_data_b;

    logic [AW-1:0]          parent_addr;
    logic [EW-1:0]          left_idx, right_idx, count_ext;
    logic                   right_ok, pick_right, move_up, move_down;
    logic [ENTRY_WIDTH-1:0] child_val;

    hpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Derive tree neighbors of the hole
    assign parent_addr = (pos_reg - AW'(1)) >> 1;
    assign left_idx    = (EW'(pos_reg) << 1) + EW'(1);
    assign right_idx   = left_idx + EW'(1);
    assign count_ext   = EW'(count_reg);

    // Compare the moving entry against parent or children
    assign move_up    = served_before(wide_entry_t'(val_reg), wide_entry_t'(rd_data_a),
                                      order_reg);
    assign right_ok   = (right_idx < count_ext);
    assign pick_right = right_ok && served_before(wide_entry_t'(rd_data_b),
                                                  wide_entry_t'(rd_data_a), order_reg);
    assign child_val  = pick_right ? rd_data_b : rd_data_a;
    assign move_down  = served_before(wide_entry_t'(child_val), wide_entry_t'(val_reg),
                                      order_reg);

    // Sequence one request through the heap
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        top_next    = top_reg;
        valid_next  = valid_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = val_reg;
        rd_addr_a   = parent_addr;
        rd_addr_b   = right_idx[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    top_next    = '0;
                    valid_next  = 1'b0;
                    status_next = STATUS_DONE;
                    if (opcode == OP_INSERT)
                    begin
                        if (count_reg >= CAP_COUNT)
                        begin
                            status_next = STATUS_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            pos_next   = count_reg[AW-1:0];
                            val_next   = entry_value;
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_RM_RD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                rd_addr_a = parent_addr;
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (move_up)
                begin
                    // Pull the parent down into the hole and climb
                    wr_data    = rd_data_a;
                    pos_next   = parent_addr;
                    state_next = S_UP_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RM_RD:
            begin
                // Fetch root and the last entry together
                rd_addr_a  = '0;
                rd_addr_b  = count_reg[AW-1:0];
                state_next = S_RM_CAP;
            end

            S_RM_CAP:
            begin
                top_next   = rd_data_a;
                valid_next = 1'b1;
                val_next   = rd_data_b;
                pos_next   = '0;
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_DN_RD:
            begin
                rd_addr_a = left_idx[AW-1:0];
                rd_addr_b = right_idx[AW-1:0];
                if (left_idx >= count_ext)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (move_down)
                begin
                    // Lift the chosen child into the hole and descend
                    wr_data    = child_val;
                    pos_next   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            order_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                order_reg <= cfg_wr_data;
            end
        end
    end

    // Hold working and result payload
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        top_reg    <= top_next;
        valid_reg  <= valid_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign top_entry   = top_reg;
    assign top_valid   = valid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count exceeds capacity");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_FULL) |-> count_reg == CAP_COUNT)
        else $error("full status reported below capacity");

    a_valid_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && valid_reg) |-> status_reg == STATUS_DONE)
        else $error("removed entry reported with error status");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg != S_IDLE)
        else $error("heap write while idle");
`endif

endmodule

`default_nettype wire
